[design/cpra_pkg.sv]
// Shared types and codes for the contiguous page run allocator.
// Used by the controller, the datapath and the top level. No dependencies.
`default_nettype none
package cpra_pkg;

    localparam logic [1:0] OP_SET_PAGE = 2'd0;
    localparam logic [1:0] OP_ALLOC    = 2'd1;
    localparam logic [1:0] OP_FREE     = 2'd2;
    localparam logic [1:0] OP_RESERVED = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NORUN = 2'd1;
    localparam logic [1:0] ST_BAD   = 2'd2;

    localparam logic [4:0] PAGE_SIZE_LOG2_RESET = 5'd21;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic decode;
        logic set_write;
        logic res_set;
        logic res_bad;
        logic res_norun;
        logic scan_init;
        logic scan_step;
        logic scan_close;
        logic grant;
        logic walk_init;
        logic walk_step;
        logic capture;
        logic out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] op;
        logic       set_ok;
        logic       free_ok;
        logic       need_zero;
        logic       scan_done;
        logic       found;
        logic       walk_end;
    } sts_t;

endpackage
`default_nettype wire

[design/cpra_ctrl.sv]
// Controller state machine of the page run allocator.
// Depends on cpra_pkg; drives cpra_datapath through cmd_t and reads sts_t.
`default_nettype none
module cpra_ctrl (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  wire               m_tready,
    input  cpra_pkg::sts_t    sts,
    output cpra_pkg::cmd_t    cmd
);
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_CHECK  = 4'd2;
    localparam logic [3:0] S_SCAN   = 4'd3;
    localparam logic [3:0] S_CLOSE  = 4'd4;
    localparam logic [3:0] S_GRANT  = 4'd5;
    localparam logic [3:0] S_WALK   = 4'd6;
    localparam logic [3:0] S_READ   = 4'd7;
    localparam logic [3:0] S_CAP    = 4'd8;
    localparam logic [3:0] S_RESULT = 4'd9;

    logic [3:0] state_reg, state_next;
    logic       m_tvalid_reg, m_tvalid_next;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        cmd           = '0;
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                cmd.decode = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK: begin
                state_next = S_RESULT;
                unique case (sts.op)
                    cpra_pkg::OP_SET_PAGE: begin
                        if (sts.set_ok) begin
                            cmd.set_write = 1'b1;
                            cmd.res_set   = 1'b1;
                        end else begin
                            cmd.res_bad = 1'b1;
                        end
                    end
                    cpra_pkg::OP_ALLOC: begin
                        if (sts.need_zero) begin
                            cmd.res_bad = 1'b1;
                        end else begin
                            cmd.scan_init = 1'b1;
                            state_next    = S_SCAN;
                        end
                    end
                    cpra_pkg::OP_FREE: begin
                        if (sts.free_ok) begin
                            cmd.walk_init = 1'b1;
                            state_next    = S_WALK;
                        end else begin
                            cmd.res_bad = 1'b1;
                        end
                    end
                    default: cmd.res_bad = 1'b1;
                endcase
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
                if (sts.scan_done) state_next = S_CLOSE;
            end
            S_CLOSE: begin
                cmd.scan_close = 1'b1;
                state_next     = S_GRANT;
            end
            S_GRANT: begin
                if (sts.found) begin
                    cmd.grant  = 1'b1;
                    state_next = S_READ;
                end else begin
                    cmd.res_norun = 1'b1;
                    state_next    = S_RESULT;
                end
            end
            S_WALK: begin
                cmd.walk_step = 1'b1;
                if (sts.walk_end) state_next = S_READ;
            end
            S_READ: begin
                // The table read of the run's first page is in flight.
                state_next = S_CAP;
            end
            S_CAP: begin
                cmd.capture = 1'b1;
                state_next  = S_RESULT;
            end
            S_RESULT: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.out_load  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule
`default_nettype wire

[design/cpra_datapath.sv]
// Datapath of the page run allocator: address table, page flags, run scan,
// grant and release logic, result registers. Depends on cpra_pkg.
`default_nettype none
module cpra_datapath #(
    parameter int PAGES = 128
) (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               cfg_we,
    input  wire  [4:0]        cfg_wdata,
    input  wire  [1:0]        in_op,
    input  wire  [6:0]        in_page,
    input  wire  [63:0]       in_addr,
    input  wire  [47:0]       in_bytes,
    input  cpra_pkg::cmd_t    cmd,
    output cpra_pkg::sts_t    sts,
    output logic [1:0]        out_status,
    output logic [6:0]        out_first,
    output logic [7:0]        out_count,
    output logic [63:0]       out_addr
);
    localparam int IW = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int CW = $clog2(PAGES + 1);

    logic [63:0]       mem [PAGES];
    logic [63:0]       rd_data_reg;
    logic [IW-1:0]     rd_idx;

    logic [4:0]        cfg_reg;
    logic [1:0]        op_reg;
    logic [6:0]        page_reg;
    logic [63:0]       addr_reg;
    logic [47:0]       bytes_reg;
    logic [48:0]       need_reg;

    logic [PAGES-1:0]  free_reg, used_reg, head_reg, tail_reg;

    logic [CW-1:0]     i_reg;
    logic [IW-1:0]     j_reg;
    logic              pv_reg;
    logic              in_run_reg;
    logic [63:0]       prev_reg;
    logic [IW-1:0]     run_start_reg, best_start_reg;
    logic [CW-1:0]     run_len_reg, best_len_reg;
    logic              found_reg;

    logic [IW-1:0]     t_reg;
    logic [1:0]        res_status_reg;
    logic [IW-1:0]     res_first_reg;
    logic [CW-1:0]     res_count_reg;
    logic [63:0]       res_addr_reg;

    logic [1:0]        out_status_reg;
    logic [6:0]        out_first_reg;
    logic [7:0]        out_count_reg;
    logic [63:0]       out_addr_reg;

    logic [IW-1:0]     p_idx;
    logic              p_in_range;
    logic [63:0]       step_bytes;
    logic [48:0]       need_sum;
    logic              join_prev;
    logic              ev_valid;
    logic              ev_fits;
    logic [CW-1:0]     g_end, g_first;
    logic [PAGES-1:0]  g_mask;
    logic              walk_end;

    assign p_idx      = IW'(page_reg);
    assign p_in_range = 32'(page_reg) < 32'(PAGES);
    assign step_bytes = 64'(1) << cfg_reg;
    assign need_sum   = {1'b0, bytes_reg} + ((49'(1) << cfg_reg) - 49'(1));

    assign join_prev = pv_reg && free_reg[j_reg] && in_run_reg
                       && ((prev_reg + step_bytes) == rd_data_reg);
    // A run is judged when a non-extending page or the scan's end closes it.
    assign ev_valid  = (cmd.scan_step && pv_reg && in_run_reg && !join_prev)
                       || (cmd.scan_close && in_run_reg);
    assign ev_fits   = (49'(run_len_reg) >= need_reg)
                       && (!found_reg || (run_len_reg < best_len_reg));

    assign g_end   = CW'(best_start_reg) + best_len_reg - CW'(1);
    assign g_first = g_end - CW'(need_reg) + CW'(1);
    always_comb begin
        for (int k = 0; k < PAGES; k++) begin
            g_mask[k] = (CW'(k) >= g_first) && (CW'(k) <= g_end);
        end
    end

    assign walk_end = tail_reg[t_reg] || (t_reg == IW'(PAGES - 1));
    assign rd_idx   = cmd.scan_step ? i_reg[IW-1:0] : res_first_reg;

    assign sts.op        = op_reg;
    assign sts.set_ok    = p_in_range && !used_reg[p_idx];
    assign sts.free_ok   = p_in_range && head_reg[p_idx];
    assign sts.need_zero = (need_reg == '0);
    assign sts.scan_done = pv_reg && (i_reg == CW'(PAGES));
    assign sts.found     = found_reg;
    assign sts.walk_end  = walk_end;

    assign out_status = out_status_reg;
    assign out_first  = out_first_reg;
    assign out_count  = out_count_reg;
    assign out_addr   = out_addr_reg;

    always_ff @(posedge aclk) begin
        if (cmd.set_write) mem[p_idx] <= addr_reg;
        rd_data_reg <= mem[rd_idx];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= cpra_pkg::PAGE_SIZE_LOG2_RESET;
        end else if (cfg_we) begin
            cfg_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_reg <= '0;
            used_reg <= '0;
            head_reg <= '0;
            tail_reg <= '0;
        end else if (cmd.set_write) begin
            free_reg[p_idx] <= 1'b1;
        end else if (cmd.grant) begin
            free_reg <= free_reg & ~g_mask;
            used_reg <= used_reg | g_mask;
            head_reg[g_first[IW-1:0]] <= 1'b1;
            tail_reg[g_end[IW-1:0]]   <= 1'b1;
        end else if (cmd.walk_step) begin
            free_reg[t_reg] <= 1'b1;
            used_reg[t_reg] <= 1'b0;
            if (walk_end) begin
                head_reg[p_idx] <= 1'b0;
                tail_reg[t_reg] <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg     <= 1'b0;
            in_run_reg <= 1'b0;
            found_reg  <= 1'b0;
        end else begin
            if (cmd.scan_init) begin
                pv_reg     <= 1'b0;
                in_run_reg <= 1'b0;
                found_reg  <= 1'b0;
            end else if (cmd.scan_step) begin
                pv_reg <= (i_reg != CW'(PAGES));
                if (pv_reg) begin
                    in_run_reg <= free_reg[j_reg];
                end
            end
            if (ev_valid && ev_fits) found_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg    <= in_op;
            page_reg  <= in_page;
            addr_reg  <= in_addr;
            bytes_reg <= in_bytes;
        end
        if (cmd.decode) need_reg <= need_sum >> cfg_reg;
        if (cmd.scan_init) i_reg <= '0;
        if (cmd.scan_step) begin
            if (i_reg != CW'(PAGES)) begin
                j_reg <= i_reg[IW-1:0];
                i_reg <= i_reg + CW'(1);
            end
            if (pv_reg) begin
                prev_reg <= rd_data_reg;
                if (join_prev) begin
                    run_len_reg <= run_len_reg + CW'(1);
                end else begin
                    run_start_reg <= j_reg;
                    run_len_reg   <= CW'(1);
                end
            end
        end
        if (ev_valid && ev_fits) begin
            best_start_reg <= run_start_reg;
            best_len_reg   <= run_len_reg;
        end
        if (cmd.walk_init) begin
            t_reg         <= p_idx;
            res_first_reg <= p_idx;
        end else if (cmd.walk_step) begin
            if (walk_end) begin
                res_count_reg <= CW'(t_reg) - CW'(p_idx) + CW'(1);
            end else begin
                t_reg <= t_reg + IW'(1);
            end
        end
        if (cmd.grant) begin
            res_first_reg <= g_first[IW-1:0];
            res_count_reg <= CW'(need_reg);
        end
        if (cmd.res_set) begin
            res_status_reg <= cpra_pkg::ST_OK;
            res_first_reg  <= p_idx;
            res_count_reg  <= CW'(1);
            res_addr_reg   <= addr_reg;
        end else if (cmd.res_bad || cmd.res_norun) begin
            res_status_reg <= cmd.res_bad ? cpra_pkg::ST_BAD : cpra_pkg::ST_NORUN;
            res_first_reg  <= '0;
            res_count_reg  <= '0;
            res_addr_reg   <= '0;
        end else if (cmd.capture) begin
            res_status_reg <= cpra_pkg::ST_OK;
            res_addr_reg   <= rd_data_reg;
        end
        if (cmd.out_load) begin
            out_status_reg <= res_status_reg;
            out_first_reg  <= 7'(res_first_reg);
            out_count_reg  <= 8'(res_count_reg);
            out_addr_reg   <= res_addr_reg;
        end
    end

endmodule
`default_nettype wire

[design/contiguous_page_run_allocator.sv]
// Each item is decoded and checked; set_page and rejected items then finish.
// An alloc scans the table one entry per cycle, closes, then grants or finds no
// run; an alloc that grants and a free that walks its run read the first address.
// s_tready returns the cycle after the result is loaded, later while an older
// result still waits in the output register; one item is in work at a time.
// Reset (aresetn low, synchronous) clears all page flags and sets page_size_log2 to 21.
`default_nettype none
module contiguous_page_run_allocator #(
    parameter int PAGES = 128
) (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          cfg_we,
    input  wire  [4:0]   cfg_wdata,    // page_size_log2
    input  wire          s_tvalid,
    output logic         s_tready,
    input  wire  [119:0] s_tdata,      // page_index[6:0], phys_addr, request_bytes
    input  wire  [1:0]   s_tuser,      // operation
    output logic         m_tvalid,
    input  wire          m_tready,
    output logic [79:0]  m_tdata,      // first_page[6:0], page_count, run_phys_addr
    output logic [1:0]   m_tuser       // status
);
    cpra_pkg::cmd_t cmd;
    cpra_pkg::sts_t sts;
    logic [6:0]  out_first;
    logic [7:0]  out_count;
    logic [63:0] out_addr;

    cpra_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    cpra_datapath #(.PAGES(PAGES)) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_op      (s_tuser),
        .in_page    (s_tdata[6:0]),
        .in_addr    (s_tdata[70:7]),
        .in_bytes   (s_tdata[118:71]),
        .cmd        (cmd),
        .sts        (sts),
        .out_status (m_tuser),
        .out_first  (out_first),
        .out_count  (out_count),
        .out_addr   (out_addr)
    );

    assign m_tdata = {1'b0, out_addr, out_count, out_first};

endmodule
`default_nettype wire

[design/cpra_checker.sv]
// Port-level checks for the page run allocator, bound to the top level.
// Depends on the top level's ports and the status codes in cpra_pkg.
`default_nettype none
module cpra_checker (
    input wire         aclk,
    input wire         aresetn,
    input wire         s_tvalid,
    input wire         s_tready,
    input wire         m_tvalid,
    input wire         m_tready,
    input wire [79:0]  m_tdata,
    input wire [1:0]   m_tuser
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == cpra_pkg::ST_OK) || (m_tuser == cpra_pkg::ST_NORUN)
                     || (m_tuser == cpra_pkg::ST_BAD))
        else $error("unknown status code");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != cpra_pkg::ST_OK |-> m_tdata == 80'd0)
        else $error("failed item carries data");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while one is in work");

endmodule

bind contiguous_page_run_allocator cpra_checker u_cpra_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire
